// ----- hw/rtl/olid_pkg.sv -----
// shared constants, mode codes and controller/datapath handshake structs
// for the ordered list block; no dependencies
`default_nettype none

package olid_pkg;

  localparam int CAPACITY = 16;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] MODE_FRONT  = 2'd0;
  localparam logic [1:0] MODE_BACK   = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_LIST   = 2'd3;

  typedef struct packed {
    logic take;    // latch the incoming item
    logic update;  // apply the item to the list, rewind the read index
    logic load;    // move the next listing entry into the output register
  } olid_cmd_t;

  typedef struct packed {
    logic list_last;  // read index points at the final listing entry
    logic slot_free;  // output register is empty or being taken this cycle
  } olid_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/olid_ctrl.sv -----
// controller state machine: accept, update, then walk the list out
// depends on olid_pkg
`default_nettype none

module olid_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  olid_pkg::olid_stat_t    stat,
  output olid_pkg::olid_cmd_t     cmd
);
  import olid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_UPDATE = 3'b010,
    S_LIST   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_LIST;
      end
      S_LIST: begin
        if (stat.slot_free) begin
          cmd.load = 1'b1;
          if (stat.list_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/olid_dp.sv -----
// datapath: entry registers with shift paths, entry count, read index
// and the output register; depends on olid_pkg
`default_nettype none

module olid_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [1:0]                     in_mode,
  input  wire logic signed [olid_pkg::VAL_W-1:0] in_operand,
  input  olid_pkg::olid_cmd_t                 cmd,
  output olid_pkg::olid_stat_t                stat,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [olid_pkg::VAL_W-1:0]   out_entry_value,
  output logic                                out_is_last,
  output logic                                out_list_empty,
  output logic                                out_insert_dropped
);
  import olid_pkg::*;

  logic [1:0]       mode_r;
  logic [VAL_W-1:0] operand_r;
  logic             dropped_r, dropped_nxt;

  logic [VAL_W-1:0] ent_r   [CAPACITY];
  logic [VAL_W-1:0] ent_nxt [CAPACITY];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r;
  logic             out_last_r, out_empty_r, out_dropped_r;

  logic             full;
  logic             del_ok;
  logic [IDX_W-1:0] pos_idx;
  logic             is_empty;

  assign full     = (count_r == CNT_W'(CAPACITY));
  assign pos_idx  = operand_r[IDX_W-1:0];
  // sign bit set means a negative position, which is ignored
  assign del_ok   = !operand_r[VAL_W-1] &&
                    (operand_r < {{(VAL_W-CNT_W){1'b0}}, count_r});
  assign is_empty = (count_r == '0);

  assign stat.list_last = is_empty || ((CNT_W'(idx_r) + 1'b1) == count_r);
  assign stat.slot_free = !out_valid_r || !out_stall;

  // list update
  always_comb begin
    ent_nxt     = ent_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (cmd.update) begin
      dropped_nxt = 1'b0;
      priority if ((mode_r == MODE_FRONT || mode_r == MODE_BACK) && full) begin
        dropped_nxt = 1'b1;
      end else if (mode_r == MODE_FRONT) begin
        ent_nxt[0] = operand_r;
        for (int i = 1; i < CAPACITY; i++) begin
          ent_nxt[i] = ent_r[i-1];
        end
        count_nxt = count_r + 1'b1;
      end else if (mode_r == MODE_BACK) begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (IDX_W'(i) == count_r[IDX_W-1:0]) begin
            ent_nxt[i] = operand_r;
          end
        end
        count_nxt = count_r + 1'b1;
      end else if (mode_r == MODE_DELETE && del_ok) begin
        // entries at and above the position close the gap
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (IDX_W'(i) >= pos_idx) begin
            ent_nxt[i] = ent_r[i+1];
          end
        end
        count_nxt = count_r - 1'b1;
      end else begin
        count_nxt = count_r;
      end
    end
  end

  // read index
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.update) begin
      idx_nxt = '0;
    end else if (cmd.load && !stat.list_last) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      dropped_r   <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      dropped_r   <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (cmd.take) begin
      mode_r    <= in_mode;
      operand_r <= in_operand;
    end
    if (cmd.load) begin
      out_value_r   <= is_empty ? '0 : ent_r[idx_r];
      out_last_r    <= stat.list_last;
      out_empty_r   <= is_empty;
      out_dropped_r <= dropped_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_entry_value    = out_value_r;
  assign out_is_last        = out_last_r;
  assign out_list_empty     = out_empty_r;
  assign out_insert_dropped = out_dropped_r;

endmodule

`default_nettype wire

// ----- hw/rtl/ordered_list_insert_delete.sv -----
// ordered list of up to 16 signed values: insert front/back, delete at position, or list only
// sequence: accept, update, then the listing one entry per cycle while out_stall is low
// a new item is taken only after the read port has walked the whole listing
//   into the output register
// reset: synchronous active-low rst_n empties the list; entry contents undefined
`default_nettype none

module ordered_list_insert_delete (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        in_mode,
  input  wire logic signed [olid_pkg::VAL_W-1:0] in_operand,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [olid_pkg::VAL_W-1:0]      out_entry_value,
  output logic                                   out_is_last,
  output logic                                   out_list_empty,
  output logic                                   out_insert_dropped
);
  import olid_pkg::*;

  olid_cmd_t  cmd;
  olid_stat_t stat;

  olid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  olid_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_mode),
    .in_operand         (in_operand),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_entry_value    (out_entry_value),
    .out_is_last        (out_is_last),
    .out_list_empty     (out_list_empty),
    .out_insert_dropped (out_insert_dropped)
  );

endmodule

`default_nettype wire

// ----- verif/ordered_list_insert_delete_test.sv -----
// self-checking bench for ordered_list_insert_delete: directed and random items,
// listing predicted from a shadow list and compared result by result
// depends on olid_pkg and the ordered_list_insert_delete rtl
module ordered_list_insert_delete_test;
  timeunit 1ns;
  timeprecision 1ps;

  import olid_pkg::*;

  typedef struct {
    logic [1:0]              mode;
    logic signed [VAL_W-1:0] operand;
    logic                    drain;  // hold this item back until all listings are in
  } list_op_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    empty;
    logic                    dropped;
  } listing_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_mode = MODE_LIST;
  logic signed [VAL_W-1:0] in_operand = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_entry_value;
  logic                    out_is_last;
  logic                    out_list_empty;
  logic                    out_insert_dropped;

  list_op_t op_q[$];
  listing_t listing_q[$];

  logic signed [VAL_W-1:0] shadow_list [CAPACITY];
  int shadow_count = 0;
  int due_count = 0;
  int results_seen = 0;
  int fail_count = 0;
  int gen_count = 0;

  ordered_list_insert_delete dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_operand         (in_operand),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_entry_value    (out_entry_value),
    .out_is_last        (out_is_last),
    .out_list_empty     (out_list_empty),
    .out_insert_dropped (out_insert_dropped)
  );

  always #2 clk = ~clk;

  // apply one item to the shadow list and queue the listing it produces
  task automatic predict_listing(input logic [1:0] mode, input logic signed [VAL_W-1:0] operand);
    logic     dropped;
    listing_t r;
    dropped = 1'b0;
    case (mode)
      MODE_FRONT, MODE_BACK: begin
        if (shadow_count >= CAPACITY) begin
          dropped = 1'b1;
        end else if (mode == MODE_FRONT) begin
          for (int k = shadow_count; k > 0; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[0] = operand;
          shadow_count++;
        end else begin
          shadow_list[shadow_count] = operand;
          shadow_count++;
        end
      end
      MODE_DELETE: begin
        if (operand >= 0 && operand < shadow_count) begin
          for (int k = operand; k < shadow_count - 1; k++) shadow_list[k] = shadow_list[k+1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    if (shadow_count == 0) begin
      r = '{value: '0, last: 1'b1, empty: 1'b1, dropped: dropped};
      listing_q.push_back(r);
      due_count++;
    end else begin
      for (int k = 0; k < shadow_count; k++) begin
        r = '{value: shadow_list[k], last: (k == shadow_count - 1), empty: 1'b0,
              dropped: dropped};
        listing_q.push_back(r);
        due_count++;
      end
    end
  endtask

  // queue an item and keep a rough count of the list to steer positions
  task automatic add_op(input logic [1:0] mode, input logic signed [VAL_W-1:0] operand,
                        input logic drain);
    op_q.push_back('{mode: mode, operand: operand, drain: drain});
    if ((mode == MODE_FRONT || mode == MODE_BACK) && gen_count < CAPACITY) gen_count++;
    if (mode == MODE_DELETE && operand >= 0 && operand < gen_count) gen_count--;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       pick_value = 32'sh7fff_ffff;
      1:       pick_value = 32'sh8000_0000;
      2:       pick_value = -32'sd1;
      default: pick_value = $urandom;
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_position(input int count);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) pick_position = $urandom_range(0, count);
    else if (r < 85) pick_position = $urandom;
    else pick_position = -$urandom_range(1, 20);
  endfunction

  // driver
  always @(posedge clk) begin : drive
    logic fire;
    int   sent;
    fire = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        predict_listing(in_mode, in_operand);
        sent++;
      end
      if (in_valid && !fire) begin
        // stalled item stays on the port
      end else if (op_q.size() > 0 && !(op_q[0].drain && due_count != results_seen) &&
                   ((sent >= 150 && sent < 210) || $urandom_range(0, 99) >= 7)) begin
        in_valid   <= 1'b1;
        in_mode    <= op_q[0].mode;
        in_operand <= op_q[0].operand;
        void'(op_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin : watch
    listing_t want;
    logic     stall_now;
    int       seen;
    int       hold_left;
    bit       hold_done;
    if (rst_n && out_valid && !out_stall) begin
      if (listing_q.size() == 0) begin
        $error("unexpected result: entry_value %0d is_last %0b", out_entry_value, out_is_last);
        fail_count++;
      end else begin
        want = listing_q.pop_front();
        if (out_entry_value !== want.value) begin
          $error("entry_value expected %0d actual %0d", want.value, out_entry_value);
          fail_count++;
        end
        if (out_is_last !== want.last) begin
          $error("is_last expected %0b actual %0b", want.last, out_is_last);
          fail_count++;
        end
        if (out_list_empty !== want.empty) begin
          $error("list_empty expected %0b actual %0b", want.empty, out_list_empty);
          fail_count++;
        end
        if (out_insert_dropped !== want.dropped) begin
          $error("insert_dropped expected %0b actual %0b", want.dropped, out_insert_dropped);
          fail_count++;
        end
      end
      seen++;
      results_seen <= seen;
    end
    // one long hold-off so the block backs up into its input
    if (hold_left > 0) begin
      hold_left--;
      stall_now = 1'b1;
    end else if (!hold_done && seen >= 400) begin
      hold_done = 1'b1;
      hold_left = 250;
      stall_now = 1'b1;
    end else if (seen >= 1200 && seen < 1500) begin
      stall_now = 1'b0;
    end else begin
      stall_now = ($urandom_range(0, 99) < 7);
    end
    out_stall <= stall_now;
  end

  initial begin
    int r;
    // empty list, then extremes, ignored deletes and two valid deletes
    add_op(MODE_LIST,   0, 1'b0);
    add_op(MODE_DELETE, 0, 1'b0);
    add_op(MODE_FRONT,  32'sh7fff_ffff, 1'b0);
    add_op(MODE_BACK,   32'sh8000_0000, 1'b0);
    add_op(MODE_FRONT,  -32'sd1, 1'b0);
    add_op(MODE_BACK,   0, 1'b0);
    add_op(MODE_DELETE, -32'sd1, 1'b0);
    add_op(MODE_DELETE, 32'sh8000_0000, 1'b0);
    add_op(MODE_DELETE, 4, 1'b0);
    add_op(MODE_DELETE, 32'sh7fff_ffff, 1'b0);
    add_op(MODE_DELETE, 3, 1'b0);
    add_op(MODE_DELETE, 0, 1'b0);
    // fill up, then inserts into a full list
    while (gen_count < CAPACITY) add_op($urandom_range(0, 1) ? MODE_BACK : MODE_FRONT,
                                        pick_value(), 1'b0);
    add_op(MODE_FRONT, 32'sh1234_5678, 1'b0);
    add_op(MODE_BACK,  -32'sd5, 1'b0);
    for (int k = 0; k < 240; k++) begin
      r = $urandom_range(0, 99);
      // phases alternate between filling and draining the list
      if ((k / 40) % 2 == 0) r = (r < 70) ? 0 : (r < 90) ? 1 : 2;
      else r = (r < 20) ? 0 : (r < 90) ? 1 : 2;
      case (r)
        0: add_op($urandom_range(0, 1) ? MODE_BACK : MODE_FRONT, pick_value(),
                  k == 0 || k == 135 || k == 220);
        1: add_op(MODE_DELETE, pick_position(gen_count), k == 0 || k == 135 || k == 220);
        default: add_op(MODE_LIST, $urandom, k == 0 || k == 135 || k == 220);
      endcase
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (op_q.size() > 0 || in_valid || listing_q.size() > 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && listing_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("TEST FAILED");
    $finish;
  end

endmodule
